// ===== hdl/lmra_pkg.sv =====
package lmra_pkg;

    // Sizes
    localparam int MAX_NODES = 16;
    localparam int TIME_BITS = 16;
    localparam int QIDX_W    = $clog2(MAX_NODES);
    localparam int QCNT_W    = $clog2(MAX_NODES + 1);
    localparam int ID_W      = 4;
    localparam int PEER_W    = 4;
    localparam int CMD_W     = 2;
    localparam int KIND_W    = 2;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 4;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [ID_W-1:0]      OWN_ID_RST = ID_W'(1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MESSAGE = 2'd2;

    // Message kinds
    localparam logic [KIND_W-1:0] MSG_DONE    = 2'd0;
    localparam logic [KIND_W-1:0] MSG_REQUEST = 2'd1;
    localparam logic [KIND_W-1:0] MSG_REPLY   = 2'd2;

    // Result actions
    localparam logic [ACT_W-1:0] ACT_NONE      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MULTICAST = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REPLY     = 2'd2;
    localparam logic [ACT_W-1:0] ACT_GRANT     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PEERS = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GRANT,
        ST_REPLY,
        ST_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        DEST_ZERO,
        DEST_SENDER,
        DEST_QUEUE
    } t_dest_sel;

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             tick;
        logic             sync;
        logic             set_req;
        logic             clr_req;
        logic             dec_live;
        logic             dec_reply;
        logic             enqueue;
        logic             drain_start;
        logic             drain_next;
        logic             clr_queue;
        logic             emit;
        logic [ACT_W-1:0] action;
        t_dest_sel        dest_sel;
        logic             last;
    } t_dp_ctrl;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KIND_W-1:0] kind;
        logic              requesting;
        logic              live_zero;
        logic              replies_zero;
        logic              reply_one;
        logic              wins;
        logic              queue_full;
        logic              queue_empty;
        logic              drain_last;
    } t_dp_status;

endpackage

// ===== hdl/lmra_datapath.sv =====
module lmra_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lmra_pkg::t_dp_ctrl                  i_ctrl,
    output lmra_pkg::t_dp_status                o_status,
    input  logic [lmra_pkg::CMD_W-1:0]          i_command,
    input  logic [lmra_pkg::KIND_W-1:0]         i_msg_kind,
    input  logic [lmra_pkg::TIME_BITS-1:0]      i_msg_time,
    input  logic [lmra_pkg::ID_W-1:0]           i_sender_id,
    input  logic                                i_cfg_we,
    input  logic [lmra_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lmra_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    output logic                                o_valid,
    output logic [lmra_pkg::ACT_W-1:0]          o_action,
    output logic [lmra_pkg::ID_W-1:0]           o_dest_id,
    output logic [lmra_pkg::TIME_BITS-1:0]      o_stamp,
    output logic                                o_last
);

    // Captured command
    logic [lmra_pkg::CMD_W-1:0]     r_cmd;
    logic [lmra_pkg::KIND_W-1:0]    r_kind;
    logic [lmra_pkg::TIME_BITS-1:0] r_msg_time;
    logic [lmra_pkg::ID_W-1:0]      r_sender;

    // Node state
    logic [lmra_pkg::ID_W-1:0]      r_own_id;
    logic [lmra_pkg::TIME_BITS-1:0] r_clock, n_clock;
    logic [lmra_pkg::TIME_BITS-1:0] r_req_stamp;
    logic                           r_requesting;
    logic [lmra_pkg::PEER_W-1:0]    r_replies;
    logic [lmra_pkg::PEER_W-1:0]    r_live;
    logic [lmra_pkg::QCNT_W-1:0]    r_count;
    logic [lmra_pkg::QIDX_W-1:0]    r_drain_idx, n_drain_idx;
    logic [lmra_pkg::ID_W-1:0]      r_q_data;

    // Deferred queue
    logic [lmra_pkg::ID_W-1:0]      mem_q [lmra_pkg::MAX_NODES];

    // Output register
    logic                           r_out_valid;
    logic [lmra_pkg::ACT_W-1:0]     r_out_action;
    logic [lmra_pkg::ID_W-1:0]      r_out_dest;
    logic [lmra_pkg::TIME_BITS-1:0] r_out_stamp;
    logic                           r_out_last;

    logic [lmra_pkg::TIME_BITS-1:0] clk_base;
    logic [lmra_pkg::ID_W-1:0]      dest_val;

    // Lamport update: optional max with message time, then saturating +1
    always_comb begin
        clk_base = r_clock;
        if (i_ctrl.sync && (r_msg_time > r_clock)) begin
            clk_base = r_msg_time;
        end
        n_clock = r_clock;
        if (i_ctrl.tick) begin
            n_clock = (clk_base == lmra_pkg::TIME_MAX) ? clk_base
                                                       : clk_base + 1'b1;
        end
    end

    // Drain pointer
    always_comb begin
        n_drain_idx = r_drain_idx;
        if (i_ctrl.drain_start) begin
            n_drain_idx = '0;
        end else if (i_ctrl.drain_next) begin
            n_drain_idx = r_drain_idx + 1'b1;
        end
    end

    // Reply destination
    always_comb begin
        case (i_ctrl.dest_sel)
            lmra_pkg::DEST_SENDER: dest_val = r_sender;
            lmra_pkg::DEST_QUEUE:  dest_val = r_q_data;
            default:               dest_val = '0;
        endcase
    end

    // Status
    always_comb begin
        o_status.cmd          = r_cmd;
        o_status.kind         = r_kind;
        o_status.requesting   = r_requesting;
        o_status.live_zero    = (r_live == '0);
        o_status.replies_zero = (r_replies == '0);
        o_status.reply_one    = (r_replies == lmra_pkg::PEER_W'(1));
        o_status.wins         = !r_requesting || (r_msg_time < r_req_stamp) ||
                                ((r_msg_time == r_req_stamp) && (r_sender < r_own_id));
        o_status.queue_full   = (r_count == lmra_pkg::QCNT_W'(lmra_pkg::MAX_NODES));
        o_status.queue_empty  = (r_count == '0);
        o_status.drain_last   = ((lmra_pkg::QCNT_W'(r_drain_idx) + 1'b1) == r_count);
    end

    // Command capture, payload only
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd      <= i_command;
            r_kind     <= i_msg_kind;
            r_msg_time <= i_msg_time;
            r_sender   <= i_sender_id;
        end
    end

    // Node state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id     <= lmra_pkg::OWN_ID_RST;
            r_clock      <= '0;
            r_req_stamp  <= '0;
            r_requesting <= 1'b0;
            r_replies    <= '0;
            r_live       <= '0;
            r_count      <= '0;
            r_drain_idx  <= '0;
        end else begin
            r_clock     <= n_clock;
            r_drain_idx <= n_drain_idx;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lmra_pkg::CFG_OWN_ID:     r_own_id <= i_cfg_data;
                    lmra_pkg::CFG_INIT_PEERS: r_live   <= i_cfg_data;
                    default: ;
                endcase
            end else if (i_ctrl.dec_live && (r_live != '0)) begin
                r_live <= r_live - 1'b1;
            end
            if (i_ctrl.set_req) begin
                r_req_stamp  <= n_clock;
                r_requesting <= 1'b1;
                r_replies    <= r_live;
            end else if (i_ctrl.clr_req) begin
                r_requesting <= 1'b0;
                r_replies    <= '0;
            end else if (i_ctrl.dec_reply) begin
                r_replies <= r_replies - 1'b1;
            end
            if (i_ctrl.clr_queue) begin
                r_count <= '0;
            end else if (i_ctrl.enqueue) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Queue memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.enqueue) begin
            mem_q[r_count[lmra_pkg::QIDX_W-1:0]] <= r_sender;
        end
        r_q_data <= mem_q[n_drain_idx];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_ctrl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_out_action <= i_ctrl.action;
            r_out_dest   <= dest_val;
            r_out_stamp  <= n_clock;
            r_out_last   <= i_ctrl.last;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_action  = r_out_action;
    assign o_dest_id = r_out_dest;
    assign o_stamp   = r_out_stamp;
    assign o_last    = r_out_last;

endmodule

// ===== hdl/lmra_ctrl.sv =====
module lmra_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  lmra_pkg::t_dp_status   i_status,
    output lmra_pkg::t_dp_ctrl     o_ctrl
);

    lmra_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmra_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmra_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = lmra_pkg::ST_EXEC;
                end
            end
            lmra_pkg::ST_EXEC: begin
                n_state = lmra_pkg::ST_IDLE;
                case (i_status.cmd)
                    lmra_pkg::CMD_REQUEST: begin
                        if (!i_status.requesting && i_status.live_zero) begin
                            n_state = lmra_pkg::ST_GRANT;
                        end
                    end
                    lmra_pkg::CMD_RELEASE: begin
                        if (!i_status.queue_empty) begin
                            n_state = lmra_pkg::ST_DRAIN;
                        end
                    end
                    lmra_pkg::CMD_MESSAGE: begin
                        if ((i_status.kind == lmra_pkg::MSG_REQUEST) && i_status.wins) begin
                            n_state = lmra_pkg::ST_REPLY;
                        end
                    end
                    default: ;
                endcase
            end
            lmra_pkg::ST_GRANT: n_state = lmra_pkg::ST_IDLE;
            lmra_pkg::ST_REPLY: n_state = lmra_pkg::ST_IDLE;
            lmra_pkg::ST_DRAIN: begin
                if (i_status.drain_last) begin
                    n_state = lmra_pkg::ST_IDLE;
                end
            end
            default: n_state = lmra_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_ctrl          = '0;
        o_ctrl.dest_sel = lmra_pkg::DEST_ZERO;
        o_ctrl.action   = lmra_pkg::ACT_NONE;
        unique case (r_state)
            lmra_pkg::ST_IDLE: begin
                o_ctrl.load = i_start;
            end
            lmra_pkg::ST_EXEC: begin
                case (i_status.cmd)
                    lmra_pkg::CMD_REQUEST: begin
                        o_ctrl.emit = 1'b1;
                        o_ctrl.last = 1'b1;
                        if (!i_status.requesting) begin
                            o_ctrl.tick    = 1'b1;
                            o_ctrl.set_req = 1'b1;
                            o_ctrl.action  = lmra_pkg::ACT_MULTICAST;
                            o_ctrl.last    = !i_status.live_zero;
                        end
                    end
                    lmra_pkg::CMD_RELEASE: begin
                        o_ctrl.tick        = 1'b1;
                        o_ctrl.clr_req     = 1'b1;
                        o_ctrl.drain_start = 1'b1;
                        o_ctrl.emit        = i_status.queue_empty;
                        o_ctrl.last        = 1'b1;
                    end
                    lmra_pkg::CMD_MESSAGE: begin
                        o_ctrl.tick = 1'b1;
                        o_ctrl.sync = 1'b1;
                        o_ctrl.emit = 1'b1;
                        o_ctrl.last = 1'b1;
                        case (i_status.kind)
                            lmra_pkg::MSG_DONE: begin
                                o_ctrl.dec_live = 1'b1;
                            end
                            lmra_pkg::MSG_REQUEST: begin
                                // winner is answered from the reply state
                                o_ctrl.emit    = !i_status.wins;
                                o_ctrl.enqueue = !i_status.wins && !i_status.queue_full;
                            end
                            lmra_pkg::MSG_REPLY: begin
                                if (i_status.requesting && !i_status.replies_zero) begin
                                    o_ctrl.dec_reply = 1'b1;
                                    if (i_status.reply_one) begin
                                        o_ctrl.action = lmra_pkg::ACT_GRANT;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                    default: begin
                        o_ctrl.emit = 1'b1;
                        o_ctrl.last = 1'b1;
                    end
                endcase
            end
            lmra_pkg::ST_GRANT: begin
                o_ctrl.emit   = 1'b1;
                o_ctrl.action = lmra_pkg::ACT_GRANT;
                o_ctrl.last   = 1'b1;
            end
            lmra_pkg::ST_REPLY: begin
                o_ctrl.tick     = 1'b1;
                o_ctrl.emit     = 1'b1;
                o_ctrl.action   = lmra_pkg::ACT_REPLY;
                o_ctrl.dest_sel = lmra_pkg::DEST_SENDER;
                o_ctrl.last     = 1'b1;
            end
            lmra_pkg::ST_DRAIN: begin
                o_ctrl.tick       = 1'b1;
                o_ctrl.emit       = 1'b1;
                o_ctrl.action     = lmra_pkg::ACT_REPLY;
                o_ctrl.dest_sel   = lmra_pkg::DEST_QUEUE;
                o_ctrl.last       = i_status.drain_last;
                o_ctrl.drain_next = 1'b1;
                o_ctrl.clr_queue  = i_status.drain_last;
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != lmra_pkg::ST_IDLE);

endmodule

// ===== hdl/lamport_mutex_request_arbiter.sv =====
// Channel   | Direction | Handshake               | Beat
// ----------+-----------+-------------------------+------------------------------------------
// command   | in        | i_start high, o_busy low | command, msg_kind, msg_time, sender_id
// result    | out       | o_valid, one cycle only  | action, dest_id, stamp, last
// config    | in        | i_cfg_valid & o_cfg_ready| register index, 4-bit data
//
// A command is captured, then executed; a request with no live peers, or a peer
// request that is answered, then passes through the grant or reply state. Release
// sends its deferred replies one by one from the queue, which has a single read port.
// Results leave through a register in the cycle after the step that makes them.
// Reset is synchronous, active low; the config port opens in the cycle after reset release.
// The receiver cannot stall; each result is shown for exactly one cycle.
module lamport_mutex_request_arbiter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [lmra_pkg::CMD_W-1:0]          i_command,
    input  logic [lmra_pkg::KIND_W-1:0]         i_msg_kind,
    input  logic [lmra_pkg::TIME_BITS-1:0]      i_msg_time,
    input  logic [lmra_pkg::ID_W-1:0]           i_sender_id,
    output logic                                o_valid,
    output logic [lmra_pkg::ACT_W-1:0]          o_action,
    output logic [lmra_pkg::ID_W-1:0]           o_dest_id,
    output logic [lmra_pkg::TIME_BITS-1:0]      o_stamp,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lmra_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lmra_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    lmra_pkg::t_dp_ctrl   ctrl;
    lmra_pkg::t_dp_status status;
    logic                 r_cfg_ready;

    // Config port opens once out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ready <= 1'b0;
        end else begin
            r_cfg_ready <= 1'b1;
        end
    end

    assign o_cfg_ready = r_cfg_ready;

    lmra_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    lmra_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_status    (status),
        .i_command   (i_command),
        .i_msg_kind  (i_msg_kind),
        .i_msg_time  (i_msg_time),
        .i_sender_id (i_sender_id),
        .i_cfg_we    (i_cfg_valid && r_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_action    (o_action),
        .o_dest_id   (o_dest_id),
        .o_stamp     (o_stamp),
        .o_last      (o_last)
    );

endmodule

// ===== hdl/lmra_checker.sv =====
module lmra_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                o_busy,
    input  logic [lmra_pkg::CMD_W-1:0]          i_command,
    input  logic [lmra_pkg::KIND_W-1:0]         i_msg_kind,
    input  logic [lmra_pkg::TIME_BITS-1:0]      i_msg_time,
    input  logic [lmra_pkg::ID_W-1:0]           i_sender_id,
    input  logic                                o_valid,
    input  logic [lmra_pkg::ACT_W-1:0]          o_action,
    input  logic [lmra_pkg::ID_W-1:0]           o_dest_id,
    input  logic [lmra_pkg::TIME_BITS-1:0]      o_stamp,
    input  logic                                o_last,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [lmra_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lmra_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    // An accepted command keeps the block busy for its execute cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted command did not raise busy");

    // Only replies carry a destination
    a_dest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action != lmra_pkg::ACT_REPLY)) |-> (o_dest_id == '0))
        else $error("non-reply beat with a destination");

    // A multicast that is not last is followed at once by the grant
    a_mcast_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == lmra_pkg::ACT_MULTICAST) && !o_last) |=>
        (o_valid && (o_action == lmra_pkg::ACT_GRANT) && o_last))
        else $error("multicast without following grant");

    // More beats pending means the command is still being worked on
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_busy)
        else $error("non-final beat while idle");

    // The last beat of one command is never directly followed by another beat
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("beat straight after a final beat");

endmodule

bind lamport_mutex_request_arbiter lmra_checker u_lmra_checker (.*);

// ===== dv/tb_lamport_mutex_request_arbiter.sv =====
`timescale 1ns / 1ps

module tb_lamport_mutex_request_arbiter;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYC  = 24;

    // One result beat as the node emits it
    typedef struct packed {
        logic [lmra_pkg::ACT_W-1:0]     action;
        logic [lmra_pkg::ID_W-1:0]      dest;
        logic [lmra_pkg::TIME_BITS-1:0] stamp;
        logic                           last;
    } t_node_result;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_start     = 1'b0;
    logic                            o_busy;
    logic [lmra_pkg::CMD_W-1:0]      i_command   = lmra_pkg::CMD_REQUEST;
    logic [lmra_pkg::KIND_W-1:0]     i_msg_kind  = lmra_pkg::MSG_DONE;
    logic [lmra_pkg::TIME_BITS-1:0]  i_msg_time  = '0;
    logic [lmra_pkg::ID_W-1:0]       i_sender_id = '0;
    logic                            o_valid;
    logic [lmra_pkg::ACT_W-1:0]      o_action;
    logic [lmra_pkg::ID_W-1:0]       o_dest_id;
    logic [lmra_pkg::TIME_BITS-1:0]  o_stamp;
    logic                            o_last;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [lmra_pkg::CFG_IDX_W-1:0]  i_cfg_index = lmra_pkg::CFG_OWN_ID;
    logic [lmra_pkg::CFG_DAT_W-1:0]  i_cfg_data  = '0;

    // Node state as predicted
    logic [lmra_pkg::TIME_BITS-1:0]  lamport_now  = '0;
    logic [lmra_pkg::TIME_BITS-1:0]  my_req_stamp = '0;
    logic                            want_section = 1'b0;
    logic [lmra_pkg::PEER_W-1:0]     replies_due  = '0;
    logic [lmra_pkg::PEER_W-1:0]     live_count   = '0;
    logic [lmra_pkg::ID_W-1:0]       my_id        = lmra_pkg::OWN_ID_RST;
    logic [lmra_pkg::ID_W-1:0]       deferred_q [lmra_pkg::MAX_NODES];
    int                              deferred_len = 0;

    t_node_result                    due_results [$];
    int                              n_fail      = 0;
    int                              stall_cycles = 0;
    int                              burst_left  = 0;

    lamport_mutex_request_arbiter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_command   (i_command),
        .i_msg_kind  (i_msg_kind),
        .i_msg_time  (i_msg_time),
        .i_sender_id (i_sender_id),
        .o_valid     (o_valid),
        .o_action    (o_action),
        .o_dest_id   (o_dest_id),
        .o_stamp     (o_stamp),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Lamport clock advance, saturating at the top
    function automatic void lamport_tick();
        if (lamport_now != lmra_pkg::TIME_MAX) begin
            lamport_now = lamport_now + 1'b1;
        end
    endfunction

    function automatic void push_result(input logic [lmra_pkg::ACT_W-1:0] act,
                                        input logic [lmra_pkg::ID_W-1:0] dst);
        t_node_result r;
        r.action = act;
        r.dest   = dst;
        r.stamp  = lamport_now;
        r.last   = 1'b0;
        due_results.push_back(r);
    endfunction

    // Predict the result beats of one accepted command
    function automatic void predict_node_step(input logic [lmra_pkg::CMD_W-1:0] cmd,
                                              input logic [lmra_pkg::KIND_W-1:0] kind,
                                              input logic [lmra_pkg::TIME_BITS-1:0] mtime,
                                              input logic [lmra_pkg::ID_W-1:0] sender);
        int  n_out;
        bit  peer_wins;
        n_out = 0;
        case (cmd)
            lmra_pkg::CMD_REQUEST: begin
                if (!want_section) begin
                    lamport_tick();
                    my_req_stamp = lamport_now;
                    want_section = 1'b1;
                    replies_due  = live_count;
                    push_result(lmra_pkg::ACT_MULTICAST, '0);
                    n_out++;
                    if (replies_due == 0) begin
                        push_result(lmra_pkg::ACT_GRANT, '0);
                        n_out++;
                    end
                end
            end
            lmra_pkg::CMD_RELEASE: begin
                lamport_tick();
                for (int i = 0; i < deferred_len; i++) begin
                    lamport_tick();
                    push_result(lmra_pkg::ACT_REPLY, deferred_q[i]);
                    n_out++;
                end
                deferred_len = 0;
                want_section = 1'b0;
                replies_due  = '0;
            end
            lmra_pkg::CMD_MESSAGE: begin
                if (mtime > lamport_now) begin
                    lamport_now = mtime;
                end
                lamport_tick();
                case (kind)
                    lmra_pkg::MSG_DONE: begin
                        if (live_count != 0) begin
                            live_count = live_count - 1'b1;
                        end
                    end
                    lmra_pkg::MSG_REQUEST: begin
                        peer_wins = !want_section || (mtime < my_req_stamp) ||
                                    (mtime == my_req_stamp && sender < my_id);
                        if (peer_wins) begin
                            lamport_tick();
                            push_result(lmra_pkg::ACT_REPLY, sender);
                            n_out++;
                        end else if (deferred_len < lmra_pkg::MAX_NODES) begin
                            deferred_q[deferred_len] = sender;
                            deferred_len++;
                        end
                    end
                    lmra_pkg::MSG_REPLY: begin
                        if (want_section && replies_due != 0) begin
                            replies_due = replies_due - 1'b1;
                            if (replies_due == 0) begin
                                push_result(lmra_pkg::ACT_GRANT, '0);
                                n_out++;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        if (n_out == 0) begin
            push_result(lmra_pkg::ACT_NONE, '0);
        end
        due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    // Result checker: every strobe must match the oldest expectation
    always @(posedge i_clk) begin
        t_node_result exp_r;
        if (i_rst_n && o_valid) begin
            if (due_results.size() == 0) begin
                $error("unexpected result beat: action %0d dest %0d stamp %0d last %0d",
                       o_action, o_dest_id, o_stamp, o_last);
                n_fail++;
            end else begin
                exp_r = due_results.pop_front();
                if (o_action !== exp_r.action) begin
                    $error("action: expected %0d, got %0d", exp_r.action, o_action);
                    n_fail++;
                end
                if (o_dest_id !== exp_r.dest) begin
                    $error("dest_id: expected %0d, got %0d", exp_r.dest, o_dest_id);
                    n_fail++;
                end
                if (o_stamp !== exp_r.stamp) begin
                    $error("stamp: expected %0d, got %0d", exp_r.stamp, o_stamp);
                    n_fail++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, o_last);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: cycles without any beat moving
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("lamport_mutex_request_arbiter verification failed");
        $finish;
    end

    // Send one command beat after a random gap, then predict its results
    task automatic issue_command(input logic [lmra_pkg::CMD_W-1:0] cmd,
                                 input logic [lmra_pkg::KIND_W-1:0] kind,
                                 input logic [lmra_pkg::TIME_BITS-1:0] mtime,
                                 input logic [lmra_pkg::ID_W-1:0] sender);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else if ($urandom_range(0, 9) == 0) begin
            gap = 0;
            burst_left = $urandom_range(4, 12);
        end else begin
            gap = $urandom_range(0, 18);
        end
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start     <= 1'b1;
        i_command   <= cmd;
        i_msg_kind  <= kind;
        i_msg_time  <= mtime;
        i_sender_id <= sender;
        do @(posedge i_clk); while (o_busy);
        predict_node_step(cmd, kind, mtime, sender);
    endtask

    // Drop start and let every expected beat arrive, then a short pause
    task automatic drain_outstanding(input int pause);
        i_start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (pause) @(posedge i_clk);
    endtask

    // Write both registers while the node is idle
    task automatic set_config(input logic [lmra_pkg::ID_W-1:0] id,
                              input logic [lmra_pkg::PEER_W-1:0] peers);
        drain_outstanding(4);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= lmra_pkg::CFG_OWN_ID;
        i_cfg_data  <= id;
        do @(posedge i_clk); while (!o_cfg_ready);
        my_id = id;
        i_cfg_index <= lmra_pkg::CFG_INIT_PEERS;
        i_cfg_data  <= peers;
        do @(posedge i_clk); while (!o_cfg_ready);
        live_count = peers;
        i_cfg_valid <= 1'b0;
    endtask

    // Reset config, then tie-breaks, deferral and the idle corners
    task automatic test_directed();
        issue_command(lmra_pkg::CMD_REQUEST, lmra_pkg::MSG_DONE, '0, '0);
        issue_command(lmra_pkg::CMD_REQUEST, lmra_pkg::MSG_REPLY, 16'hFFFF, 4'hF);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REPLY, '0, 4'd2);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REQUEST, '0, 4'd9);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REQUEST, my_req_stamp, 4'd0);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REQUEST, my_req_stamp, 4'd5);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REQUEST, 16'h0123, 4'hF);
        issue_command(lmra_pkg::CMD_RELEASE, lmra_pkg::MSG_DONE, '0, '0);
        issue_command(lmra_pkg::CMD_RELEASE, lmra_pkg::MSG_REQUEST, 16'hAAAA, 4'hA);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_DONE, '0, 4'd3);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REPLY, 16'h00F0, 4'd6);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REQUEST, 16'd5, 4'd2);
        // two live peers, own id at the top
        set_config(4'd15, 4'd2);
        issue_command(lmra_pkg::CMD_REQUEST, lmra_pkg::MSG_DONE, 16'h5555, 4'd5);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REPLY, lamport_now, 4'd1);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_DONE, lamport_now, 4'd2);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REQUEST, my_req_stamp, 4'd14);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REQUEST, my_req_stamp, 4'd15);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REPLY, lamport_now, 4'd3);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REPLY, lamport_now, 4'd4);
        issue_command(lmra_pkg::CMD_RELEASE, lmra_pkg::MSG_REPLY, '0, '0);
    endtask

    // Seventeen losing peer requests: the queue fills, one is dropped
    task automatic test_queue_full();
        set_config(4'd8, 4'd1);
        issue_command(lmra_pkg::CMD_REQUEST, lmra_pkg::MSG_DONE, '0, '0);
        repeat (lmra_pkg::MAX_NODES + 1) begin
            issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REQUEST,
                          my_req_stamp + lmra_pkg::TIME_BITS'($urandom_range(1, 50)),
                          lmra_pkg::ID_W'($urandom_range(0, 15)));
        end
        issue_command(lmra_pkg::CMD_RELEASE, lmra_pkg::MSG_DONE, '0, '0);
    endtask

    // Request / message / release sessions with random content and some noise
    task automatic test_random_sessions();
        logic [lmra_pkg::ID_W-1:0]      ids   [4];
        logic [lmra_pkg::PEER_W-1:0]    peers [4];
        logic [lmra_pkg::TIME_BITS-1:0] t;
        int                             sent;
        int                             n_msg;
        int                             pick;
        ids   = '{4'd1, 4'd15, 4'd9, 4'd4};
        peers = '{4'd0, 4'd15, 4'd3, 4'd1};
        for (int p = 0; p < 4; p++) begin
            set_config(ids[p], peers[p]);
            sent = 0;
            while (sent < 14) begin
                if ($urandom_range(0, 7) == 0) begin
                    issue_command(lmra_pkg::CMD_W'($urandom_range(lmra_pkg::CMD_REQUEST,
                                                                  lmra_pkg::CMD_MESSAGE)),
                                  lmra_pkg::KIND_W'($urandom_range(lmra_pkg::MSG_DONE,
                                                                   lmra_pkg::MSG_REPLY)),
                                  lamport_now + lmra_pkg::TIME_BITS'($urandom_range(0, 5)),
                                  lmra_pkg::ID_W'($urandom_range(0, 15)));
                    sent++;
                end
                issue_command(lmra_pkg::CMD_REQUEST,
                              lmra_pkg::KIND_W'($urandom_range(lmra_pkg::MSG_DONE,
                                                               lmra_pkg::MSG_REPLY)),
                              lmra_pkg::TIME_BITS'($urandom), lmra_pkg::ID_W'($urandom));
                sent++;
                n_msg = live_count + $urandom_range(0, 4);
                for (int m = 0; m < n_msg; m++) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 12 || pick == 17) begin
                        // reply or done, stamped near or below the local clock
                        if ($urandom_range(0, 1) == 1) begin
                            t = lamport_now + lmra_pkg::TIME_BITS'($urandom_range(0, 3));
                        end else begin
                            t = lmra_pkg::TIME_BITS'($urandom_range(0, lamport_now));
                        end
                        issue_command(lmra_pkg::CMD_MESSAGE,
                                      (pick == 17) ? lmra_pkg::MSG_DONE : lmra_pkg::MSG_REPLY,
                                      t, lmra_pkg::ID_W'($urandom_range(0, 15)));
                    end else if (pick < 17) begin
                        // peer request close to our own stamp to hit both sides of the tie
                        case ($urandom_range(0, 3))
                            0: t = (my_req_stamp != 0) ? my_req_stamp - 1'b1 : '0;
                            1: t = my_req_stamp;
                            2: t = my_req_stamp + lmra_pkg::TIME_BITS'($urandom_range(1, 4));
                            default: t = lamport_now +
                                         lmra_pkg::TIME_BITS'($urandom_range(0, 2));
                        endcase
                        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REQUEST, t,
                                      lmra_pkg::ID_W'($urandom_range(0, 15)));
                    end else begin
                        issue_command(lmra_pkg::CMD_W'($urandom_range(lmra_pkg::CMD_REQUEST,
                                                                      lmra_pkg::CMD_MESSAGE)),
                                      lmra_pkg::KIND_W'($urandom_range(lmra_pkg::MSG_DONE,
                                                                       lmra_pkg::MSG_REPLY)),
                                      lamport_now + lmra_pkg::TIME_BITS'($urandom_range(0, 5)),
                                      lmra_pkg::ID_W'($urandom_range(0, 15)));
                    end
                    sent++;
                end
                issue_command(lmra_pkg::CMD_RELEASE,
                              lmra_pkg::KIND_W'($urandom_range(lmra_pkg::MSG_DONE,
                                                               lmra_pkg::MSG_REPLY)),
                              lmra_pkg::TIME_BITS'($urandom), lmra_pkg::ID_W'($urandom));
                sent++;
            end
        end
    endtask

    // Clock pinned at its maximum; must run last as the clock never comes down
    task automatic test_clock_saturation();
        set_config(4'd15, 4'd15);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REPLY, lmra_pkg::TIME_MAX, 4'd0);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_DONE,
                      lmra_pkg::TIME_MAX - 1'b1, 4'd7);
        issue_command(lmra_pkg::CMD_REQUEST, lmra_pkg::MSG_DONE, '0, '0);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REQUEST, lmra_pkg::TIME_MAX, 4'd3);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REQUEST, lmra_pkg::TIME_MAX, 4'd15);
        issue_command(lmra_pkg::CMD_MESSAGE, lmra_pkg::MSG_REQUEST, '0, 4'd12);
        repeat (12) begin
            issue_command(lmra_pkg::CMD_MESSAGE,
                          lmra_pkg::KIND_W'($urandom_range(lmra_pkg::MSG_DONE,
                                                           lmra_pkg::MSG_REPLY)),
                          lmra_pkg::TIME_BITS'($urandom),
                          lmra_pkg::ID_W'($urandom_range(0, 15)));
        end
        issue_command(lmra_pkg::CMD_RELEASE, lmra_pkg::MSG_DONE, '0, '0);
        issue_command(lmra_pkg::CMD_REQUEST, lmra_pkg::MSG_REPLY, '0, '0);
    endtask

    // Sequencer
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_queue_full();
        test_random_sessions();
        test_clock_saturation();
        drain_outstanding(SETTLE_CYC);
        if (n_fail == 0) begin
            $display("lamport_mutex_request_arbiter verification clean");
        end else begin
            $display("lamport_mutex_request_arbiter verification failed");
        end
        $finish;
    end

endmodule
